FILE: hw/rtl/qte_pkg.sv
// shared types, constants and the cordic arctangent table for the quaternion to euler block
// no dependencies
`default_nettype none

package qte_pkg;

   // square root units: 64-bit radicand, 32-bit root
   localparam int RAD_W  = 64;
   localparam int ROOT_W = 32;

   // cordic datapath widths
   localparam int CW = 38;   // x / y coordinates
   localparam int ZW = 29;   // angle accumulator, 1/4096 hundredth of a degree

   localparam int NUM_LANES = 3;
   localparam int LANE_ROLL  = 0;
   localparam int LANE_PITCH = 1;
   localparam int LANE_YAW   = 2;

   localparam int MAX_STEPS = 32;

   localparam logic [RAD_W-1:0] ONE_Q60 = 64'h1000_0000_0000_0000;

   typedef logic signed [CW-1:0] coord_type;
   typedef logic signed [ZW-1:0] angle_type;

   localparam angle_type QUARTER_TURN = 29'sd36864000;
   localparam angle_type ROUND_BIAS   = 29'sd2048;

   // atan(2^-i) in accumulator units, rounded to nearest
   function automatic angle_type atan_tab(input logic [4:0] idx);
      angle_type val;
      unique case (idx)
         5'd0:  val = 29'sd18432000;
         5'd1:  val = 29'sd10881045;
         5'd2:  val = 29'sd5749245;
         5'd3:  val = 29'sd2918407;
         5'd4:  val = 29'sd1464867;
         5'd5:  val = 29'sd733147;
         5'd6:  val = 29'sd366663;
         5'd7:  val = 29'sd183343;
         5'd8:  val = 29'sd91673;
         5'd9:  val = 29'sd45837;
         5'd10: val = 29'sd22918;
         5'd11: val = 29'sd11459;
         5'd12: val = 29'sd5730;
         5'd13: val = 29'sd2865;
         5'd14: val = 29'sd1432;
         5'd15: val = 29'sd716;
         5'd16: val = 29'sd358;
         5'd17: val = 29'sd179;
         5'd18: val = 29'sd90;
         5'd19: val = 29'sd45;
         5'd20: val = 29'sd22;
         5'd21: val = 29'sd11;
         5'd22: val = 29'sd6;
         5'd23: val = 29'sd3;
         5'd24: val = 29'sd1;
         5'd25: val = 29'sd1;
         5'd26: val = 29'sd0;
         5'd27: val = 29'sd0;
         5'd28: val = 29'sd0;
         5'd29: val = 29'sd0;
         5'd30: val = 29'sd0;
         5'd31: val = 29'sd0;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/quaternion_to_euler_angles.sv
// top level: quaternion (q1, q2, q3 in q30) to roll / pitch / yaw in hundredths of a degree
// depends on qte_pkg, qte_sqrt_pipe and qte_cordic_pipe
`default_nettype none

// Fully pipelined converter: one frame is taken per cycle while req_ready is high, and each usable
// frame (frame_ok and quat_present both set) yields one result; frames that are not usable are
// taken and dropped. The path runs through two 32-stage square-root pipelines (q0, then the cosine
// term for pitch), five arithmetic stages around them, the cordic pre-rotation plus one stage per
// cordic step (at most MAX_STEPS), and the output register. The whole pipeline advances as one:
// when a result sits in the output register and is not taken, every stage holds and req_ready
// drops, so nothing is lost or repeated.

module quaternion_to_euler_angles
   import qte_pkg::*;
#(
   parameter int CORDIC_STEPS = 16
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_ready,
   input  wire                req_frame_ok,
   input  wire                req_quat_present,
   input  wire signed [31:0]  req_quat_x,
   input  wire signed [31:0]  req_quat_y,
   input  wire signed [31:0]  req_quat_z,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output logic signed [15:0] rsp_roll_angle,
   output logic signed [14:0] rsp_pitch_angle,
   output logic signed [15:0] rsp_yaw_angle
);

   localparam int TW = 36;   // width of the t0..t4 terms

   typedef struct packed {
      logic signed [31:0]   q1;
      logic signed [31:0]   q2;
      logic signed [31:0]   q3;
      logic signed [63:0]   p23;
      logic signed [63:0]   p12;
      logic signed [63:0]   p31;
      logic signed [TW-1:0] t1;
      logic signed [TW-1:0] t4;
   } side1_type;

   typedef struct packed {
      logic signed [TW-1:0] t0;
      logic signed [TW-1:0] t1;
      logic signed [TW-1:0] t3;
      logic signed [TW-1:0] t4;
      logic signed [31:0]   t2;
   } side2_type;

   // global advance: the pipeline moves whenever the output register is free or being drained
   logic adv;
   logic rsp_valid_ff;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   // ---------------- stage 1: squares and cross products ----------------
   logic [31:0]        ax, ay, az;
   logic [63:0]        s1_in, s2_in, s3_in;
   logic signed [63:0] p23_in, p12_in, p31_in;

   logic               v1_ff;
   logic signed [31:0] q1_ff, q2_ff, q3_ff;
   logic [63:0]        s1_ff, s2_ff, s3_ff;
   logic signed [63:0] p23_ff, p12_ff, p31_ff;

   assign ax = req_quat_x[31] ? 32'(-req_quat_x) : 32'(req_quat_x);
   assign ay = req_quat_y[31] ? 32'(-req_quat_y) : 32'(req_quat_y);
   assign az = req_quat_z[31] ? 32'(-req_quat_z) : 32'(req_quat_z);

   assign s1_in  = ax * ax;
   assign s2_in  = ay * ay;
   assign s3_in  = az * az;
   assign p23_in = req_quat_y * req_quat_z;
   assign p12_in = req_quat_x * req_quat_y;
   assign p31_in = req_quat_z * req_quat_x;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         // a frame without usable quaternion data is taken but leaves a bubble
         v1_ff <= req_valid && req_frame_ok && req_quat_present;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         q1_ff  <= req_quat_x;
         q2_ff  <= req_quat_y;
         q3_ff  <= req_quat_z;
         s1_ff  <= s1_in;
         s2_ff  <= s2_in;
         s3_ff  <= s3_in;
         p23_ff <= p23_in;
         p12_ff <= p12_in;
         p31_ff <= p31_in;
      end
   end

   // ---------------- stage 2: radicand for q0, t1 and t4 ----------------
   logic [65:0]          sum3;
   logic [64:0]          s12, s23;
   logic [RAD_W-1:0]     rad_in;
   side1_type            side1_in;

   logic                 v2_ff;
   logic [RAD_W-1:0]     rad_ff;
   side1_type            side1_ff;

   assign sum3 = 66'(s1_ff) + 66'(s2_ff) + 66'(s3_ff);
   assign s12  = 65'(s1_ff) + 65'(s2_ff);
   assign s23  = 65'(s2_ff) + 65'(s3_ff);

   // sum of squares at or above one clamps the radicand to zero
   assign rad_in = (sum3 >= 66'(ONE_Q60)) ? '0 : RAD_W'(66'(ONE_Q60) - sum3);

   always_comb begin
      side1_in     = '0;
      side1_in.q1  = q1_ff;
      side1_in.q2  = q2_ff;
      side1_in.q3  = q3_ff;
      side1_in.p23 = p23_ff;
      side1_in.p12 = p12_ff;
      side1_in.p31 = p31_ff;
      side1_in.t1  = 36'sd1073741824 - $signed({1'b0, s12[63:29]});
      side1_in.t4  = 36'sd1073741824 - $signed({1'b0, s23[63:29]});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rad_ff   <= rad_in;
         side1_ff <= side1_in;
      end
   end

   // ---------------- q0 = sqrt(radicand) ----------------
   logic              sq1_valid;
   logic [ROOT_W-1:0] sq1_root;
   side1_type         sq1_side;

   qte_sqrt_pipe #(
      .SIDE_W ($bits(side1_type))
   ) u_sqrt_q0 (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (v2_ff),
      .in_rad    (rad_ff),
      .in_side   (side1_ff),
      .out_valid (sq1_valid),
      .out_root  (sq1_root),
      .out_side  (sq1_side)
   );

   // ---------------- stage 3: q0 products ----------------
   logic signed [31:0]   q0_s;
   logic signed [63:0]   m1_in, m2_in, m3_in;

   logic                 v3_ff;
   logic signed [63:0]   m1_ff, m2_ff, m3_ff;
   logic signed [63:0]   p23b_ff, p12b_ff, p31b_ff;
   logic signed [TW-1:0] t1a_ff, t4a_ff;

   assign q0_s  = $signed({1'b0, sq1_root[30:0]});
   assign m1_in = q0_s * sq1_side.q1;
   assign m2_in = q0_s * sq1_side.q2;
   assign m3_in = q0_s * sq1_side.q3;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= sq1_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m1_ff   <= m1_in;
         m2_ff   <= m2_in;
         m3_ff   <= m3_in;
         p23b_ff <= sq1_side.p23;
         p12b_ff <= sq1_side.p12;
         p31b_ff <= sq1_side.p31;
         t1a_ff  <= sq1_side.t1;
         t4a_ff  <= sq1_side.t4;
      end
   end

   // ---------------- stage 4: t0, t2 (clamped), t3 ----------------
   logic signed [64:0]   e0, e2, e3;
   logic signed [TW-1:0] t2_raw;
   logic signed [31:0]   t2_in;

   logic                 v4_ff;
   logic signed [TW-1:0] t0b_ff, t1b_ff, t3b_ff, t4b_ff;
   logic signed [31:0]   t2b_ff;

   assign e0     = 65'(m1_ff) + 65'(p23b_ff);
   assign e2     = 65'(m2_ff) - 65'(p31b_ff);
   assign e3     = 65'(m3_ff) + 65'(p12b_ff);
   assign t2_raw = e2[64:29];

   // asin argument limited to plus or minus one
   always_comb begin
      priority if (t2_raw < -36'sd1073741824) begin
         t2_in = -32'sd1073741824;
      end else if (t2_raw > 36'sd1073741824) begin
         t2_in = 32'sd1073741824;
      end else begin
         t2_in = 32'(t2_raw);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (adv) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t0b_ff <= e0[64:29];
         t3b_ff <= e3[64:29];
         t1b_ff <= t1a_ff;
         t4b_ff <= t4a_ff;
         t2b_ff <= t2_in;
      end
   end

   // ---------------- stage 5: t2 squared ----------------
   logic [30:0]      a2;
   logic [RAD_W-1:0] t2sq_in;
   side2_type        side2_in;

   logic             v5_ff;
   logic [RAD_W-1:0] t2sq_ff;
   side2_type        side2_ff;

   assign a2      = t2b_ff[31] ? 31'(-t2b_ff) : 31'(t2b_ff);
   assign t2sq_in = a2 * a2;

   always_comb begin
      side2_in    = '0;
      side2_in.t0 = t0b_ff;
      side2_in.t1 = t1b_ff;
      side2_in.t3 = t3b_ff;
      side2_in.t4 = t4b_ff;
      side2_in.t2 = t2b_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (adv) begin
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t2sq_ff  <= t2sq_in;
         side2_ff <= side2_in;
      end
   end

   // ---------------- c = sqrt(1 - t2^2) ----------------
   logic              sq2_valid;
   logic [ROOT_W-1:0] sq2_root;
   side2_type         sq2_side;

   qte_sqrt_pipe #(
      .SIDE_W ($bits(side2_type))
   ) u_sqrt_cos (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (v5_ff),
      .in_rad    (ONE_Q60 - t2sq_ff),
      .in_side   (side2_ff),
      .out_valid (sq2_valid),
      .out_root  (sq2_root),
      .out_side  (sq2_side)
   );

   // ---------------- three atan2 lanes ----------------
   coord_type cx [NUM_LANES];
   coord_type cy [NUM_LANES];
   logic      cd_valid;
   angle_type cd_angle [NUM_LANES];

   assign cx[LANE_ROLL]  = CW'(sq2_side.t1);
   assign cy[LANE_ROLL]  = CW'(sq2_side.t0);
   assign cx[LANE_PITCH] = CW'($signed({1'b0, sq2_root[30:0]}));
   assign cy[LANE_PITCH] = CW'(sq2_side.t2);
   assign cx[LANE_YAW]   = CW'(sq2_side.t4);
   assign cy[LANE_YAW]   = CW'(sq2_side.t3);

   qte_cordic_pipe #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (sq2_valid),
      .in_x      (cx),
      .in_y      (cy),
      .out_valid (cd_valid),
      .out_angle (cd_angle)
   );

   // ---------------- output register: round to hundredths and clamp ----------------
   angle_type          rb_roll, rb_pitch, rb_yaw;
   logic signed [16:0] rd_roll, rd_pitch, rd_yaw;
   logic signed [15:0] roll_in, yaw_in;
   logic signed [14:0] pitch_in;

   logic signed [15:0] roll_ff, yaw_ff;
   logic signed [14:0] pitch_ff;

   assign rb_roll  = cd_angle[LANE_ROLL] + ROUND_BIAS;
   assign rb_pitch = cd_angle[LANE_PITCH] + ROUND_BIAS;
   assign rb_yaw   = cd_angle[LANE_YAW] + ROUND_BIAS;
   assign rd_roll  = rb_roll[ZW-1:12];
   assign rd_pitch = rb_pitch[ZW-1:12];
   assign rd_yaw   = rb_yaw[ZW-1:12];

   always_comb begin
      priority if (rd_roll > 17'sd18000) begin
         roll_in = 16'sd18000;
      end else if (rd_roll < -17'sd18000) begin
         roll_in = -16'sd18000;
      end else begin
         roll_in = 16'(rd_roll);
      end

      priority if (rd_yaw > 17'sd18000) begin
         yaw_in = 16'sd18000;
      end else if (rd_yaw < -17'sd18000) begin
         yaw_in = -16'sd18000;
      end else begin
         yaw_in = 16'(rd_yaw);
      end

      priority if (rd_pitch > 17'sd9000) begin
         pitch_in = 15'sd9000;
      end else if (rd_pitch < -17'sd9000) begin
         pitch_in = -15'sd9000;
      end else begin
         pitch_in = 15'(rd_pitch);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= cd_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         roll_ff  <= roll_in;
         pitch_ff <= pitch_in;
         yaw_ff   <= yaw_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_roll_angle  = roll_ff;
   assign rsp_pitch_angle = pitch_ff;
   assign rsp_yaw_angle   = yaw_ff;

`ifndef SYNTHESIS
   // q0 never exceeds one in q30, since the radicand is at most one in q60
   a_q0_range: assert property (@(posedge clock) disable iff (reset)
      sq1_valid |-> (sq1_root <= 32'd1073741824))
      else $error("q0 root out of range");

   // cosine term for pitch is bounded by one as well
   a_cos_range: assert property (@(posedge clock) disable iff (reset)
      sq2_valid |-> (sq2_root <= 32'd1073741824))
      else $error("pitch cosine root out of range");

   // a held output freezes the middle of the pipeline
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !req_ready |=> ($stable(t2sq_ff) && $stable(v5_ff)))
      else $error("pipeline moved during output stall");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/qte_sqrt_pipe.sv
// pipelined integer square root, one root bit per register stage, with a sideband that travels along
// depends on qte_pkg
`default_nettype none

module qte_sqrt_pipe
   import qte_pkg::*;
#(
   parameter int SIDE_W = 1
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                en,
   input  wire                in_valid,
   input  wire [RAD_W-1:0]    in_rad,
   input  wire [SIDE_W-1:0]   in_side,
   output logic               out_valid,
   output logic [ROOT_W-1:0]  out_root,
   output logic [SIDE_W-1:0]  out_side
);

   localparam int NS    = ROOT_W;
   localparam int REM_W = ROOT_W + 4;

   logic              vld_ff  [0:NS-1];
   logic [RAD_W-1:0]  rad_ff  [0:NS-1];
   logic [REM_W-1:0]  rem_ff  [0:NS-1];
   logic [ROOT_W-1:0] root_ff [0:NS-1];
   logic [SIDE_W-1:0] side_ff [0:NS-1];

   for (genvar s = 0; s < NS; s++) begin : g_stage
      logic              vld_src;
      logic [RAD_W-1:0]  rad_src;
      logic [REM_W-1:0]  rem_src;
      logic [ROOT_W-1:0] root_src;
      logic [SIDE_W-1:0] side_src;
      logic [REM_W-1:0]  rem_sh;
      logic [REM_W-1:0]  trial;

      if (s == 0) begin : g_first
         assign vld_src  = in_valid;
         assign rad_src  = in_rad;
         assign rem_src  = '0;
         assign root_src = '0;
         assign side_src = in_side;
      end else begin : g_next
         assign vld_src  = vld_ff[s-1];
         assign rad_src  = rad_ff[s-1];
         assign rem_src  = rem_ff[s-1];
         assign root_src = root_ff[s-1];
         assign side_src = side_ff[s-1];
      end

      // bring down the next two radicand bits, try root*4+1
      assign rem_sh = {rem_src[REM_W-3:0], rad_src[RAD_W-1 -: 2]};
      assign trial  = REM_W'({root_src, 2'b01});

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (en) begin
            vld_ff[s] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[s]  <= {rad_src[RAD_W-3:0], 2'b00};
            side_ff[s] <= side_src;
            if (rem_sh >= trial) begin
               rem_ff[s]  <= rem_sh - trial;
               root_ff[s] <= {root_src[ROOT_W-2:0], 1'b1};
            end else begin
               rem_ff[s]  <= rem_sh;
               root_ff[s] <= {root_src[ROOT_W-2:0], 1'b0};
            end
         end
      end
   end

   assign out_valid = vld_ff[NS-1];
   assign out_root  = root_ff[NS-1];
   assign out_side  = side_ff[NS-1];

endmodule

`default_nettype wire

FILE: hw/rtl/qte_cordic_pipe.sv
// three-lane pipelined cordic in vectoring mode, one micro-rotation per register stage
// depends on qte_pkg
`default_nettype none

module qte_cordic_pipe
   import qte_pkg::*;
#(
   parameter int CORDIC_STEPS = 16
) (
   input  wire        clock,
   input  wire        reset,
   input  wire        en,
   input  wire        in_valid,
   input  coord_type  in_x [NUM_LANES],
   input  coord_type  in_y [NUM_LANES],
   output logic       out_valid,
   output angle_type  out_angle [NUM_LANES]
);

   localparam int RUN = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;

   // stage 0 is the quadrant pre-rotation, stages 1..RUN the micro-rotations
   logic      vld_ff  [0:RUN];
   coord_type x_ff    [0:RUN][NUM_LANES];
   coord_type y_ff    [0:RUN][NUM_LANES];
   angle_type z_ff    [0:RUN][NUM_LANES];
   logic      zero_ff [0:RUN][NUM_LANES];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
      end
   end

   for (genvar l = 0; l < NUM_LANES; l++) begin : g_pre
      always_ff @(posedge clock) begin
         if (en) begin
            zero_ff[0][l] <= (in_x[l] == '0) && (in_y[l] == '0);
            if (in_x[l][CW-1] && !in_y[l][CW-1]) begin
               x_ff[0][l] <= in_y[l];
               y_ff[0][l] <= -in_x[l];
               z_ff[0][l] <= QUARTER_TURN;
            end else if (in_x[l][CW-1]) begin
               x_ff[0][l] <= -in_y[l];
               y_ff[0][l] <= in_x[l];
               z_ff[0][l] <= -QUARTER_TURN;
            end else begin
               x_ff[0][l] <= in_x[l];
               y_ff[0][l] <= in_y[l];
               z_ff[0][l] <= '0;
            end
         end
      end
   end

   for (genvar j = 1; j <= RUN; j++) begin : g_step
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else if (en) begin
            vld_ff[j] <= vld_ff[j-1];
         end
      end

      for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
         coord_type dx;
         coord_type dy;
         angle_type step_ang;

         assign dx       = y_ff[j-1][l] >>> (j - 1);
         assign dy       = x_ff[j-1][l] >>> (j - 1);
         assign step_ang = atan_tab(5'(j - 1));

         always_ff @(posedge clock) begin
            if (en) begin
               zero_ff[j][l] <= zero_ff[j-1][l];
               if (!y_ff[j-1][l][CW-1]) begin
                  x_ff[j][l] <= x_ff[j-1][l] + dx;
                  y_ff[j][l] <= y_ff[j-1][l] - dy;
                  z_ff[j][l] <= z_ff[j-1][l] + step_ang;
               end else begin
                  x_ff[j][l] <= x_ff[j-1][l] - dx;
                  y_ff[j][l] <= y_ff[j-1][l] + dy;
                  z_ff[j][l] <= z_ff[j-1][l] - step_ang;
               end
            end
         end
      end
   end

   assign out_valid = vld_ff[RUN];

   for (genvar l = 0; l < NUM_LANES; l++) begin : g_out
      // both operands zero gives angle zero
      assign out_angle[l] = zero_ff[RUN][l] ? '0 : z_ff[RUN][l];
   end

endmodule

`default_nettype wire
